### rtl/core/poi_pkg.sv
package poi_pkg;

   // default geometry of the sine lookup
   localparam int SINE_INDEX_BITS_DEF = 10;
   localparam int TRIG_FRAC_BITS_DEF  = 15;

   // payload widths
   localparam int VEL_W  = 16;
   localparam int DT_W   = 16;
   localparam int POS_W  = 48;
   localparam int HEAD_W = 32;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   // shared multiplier and accumulator
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 17;
   localparam int ACC_W      = 65;
   localparam int GAIN_SPLIT = 16;

   // widest quarter-wave entry the generator returns
   localparam int QSINE_W = 25;

   localparam logic [63:0]             HALF_PI_Q30   = 64'd1686629713;
   localparam logic [HEAD_W-1:0]       HEAD_GAIN_Q32 = 32'd2935890503;
   localparam logic signed [POS_W-1:0] START_X_RESET = 48'sd800000000;
   localparam logic signed [POS_W-1:0] START_Y_RESET = 48'sd300000000;
   localparam logic [HEAD_W-1:0]       START_H_RESET = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X       = 2'd0,
      CSR_START_Y       = 2'd1,
      CSR_START_HEADING = 2'd2
   } poi_csr_type;

   typedef enum logic {
      KIND_TICK   = 1'b0,
      KIND_RELOAD = 1'b1
   } poi_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIN,
      ST_COS,
      ST_RUN,
      ST_DONE
   } poi_state_type;

   // micro-steps of the shared multiplier sequence
   typedef enum logic [3:0] {
      STEP_VX_COS   = 4'd0,
      STEP_VY_SIN   = 4'd1,
      STEP_VX_SIN   = 4'd2,
      STEP_VY_COS   = 4'd3,
      STEP_XLO_DT   = 4'd4,
      STEP_XHI_DT   = 4'd5,
      STEP_YLO_DT   = 4'd6,
      STEP_YHI_DT   = 4'd7,
      STEP_TURN_DT  = 4'd8,
      STEP_TURN_MAG = 4'd9,
      STEP_GAIN_LO  = 4'd10,
      STEP_GAIN_HI  = 4'd11,
      STEP_GAIN_SUM = 4'd12,
      STEP_HEADING  = 4'd13
   } poi_step_type;

   // quarter-wave sine entry m of 2^(sib-2), evaluated at elaboration only
   function automatic logic [QSINE_W-1:0] quarter_sine(input int unsigned m,
                                                       input int unsigned sib,
                                                       input int unsigned tfb);
      logic [63:0]        a;
      logic [63:0]        a2;
      logic [63:0]        term;
      logic signed [65:0] sum;
      logic signed [65:0] rnd;
      a    = (64'(m) * HALF_PI_Q30) >> (sib - 2);
      a2   = (a * a) >> 30;
      term = a;
      sum  = $signed({2'b00, a});
      term = ((term * a2) >> 30) / 64'd6;
      sum  = sum - $signed({2'b00, term});
      term = ((term * a2) >> 30) / 64'd20;
      sum  = sum + $signed({2'b00, term});
      term = ((term * a2) >> 30) / 64'd42;
      sum  = sum - $signed({2'b00, term});
      term = ((term * a2) >> 30) / 64'd72;
      sum  = sum + $signed({2'b00, term});
      term = ((term * a2) >> 30) / 64'd110;
      sum  = sum - $signed({2'b00, term});
      term = ((term * a2) >> 30) / 64'd156;
      sum  = sum + $signed({2'b00, term});
      term = ((term * a2) >> 30) / 64'd210;
      sum  = sum - $signed({2'b00, term});
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > 66'sd1073741824) begin
         sum = 66'sd1073741824;
      end
      rnd = (sum + (66'sd1 <<< (29 - tfb))) >>> (30 - tfb);
      return rnd[QSINE_W-1:0];
   endfunction

endpackage

### rtl/core/poi_channel_if.sv
interface poi_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [poi_pkg::VEL_W-1:0]    vel_x;
   logic signed [poi_pkg::VEL_W-1:0]    vel_y;
   logic signed [poi_pkg::VEL_W-1:0]    turn_rate;
   logic [poi_pkg::DT_W-1:0]            elapsed_us;

   modport source (output valid, kind, vel_x, vel_y, turn_rate, elapsed_us, input ready);
   modport sink (input valid, kind, vel_x, vel_y, turn_rate, elapsed_us, output ready);
endinterface

interface poi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [poi_pkg::POS_W-1:0]    pos_x_nm;
   logic signed [poi_pkg::POS_W-1:0]    pos_y_nm;
   logic [poi_pkg::HEAD_W-1:0]          heading_out;

   modport source (output valid, pos_x_nm, pos_y_nm, heading_out, input ready);
   modport sink (input valid, pos_x_nm, pos_y_nm, heading_out, output ready);
endinterface

### rtl/core/planar_odometry_integrator_top.sv
// channel   dir  transaction                          payload
// req_bus   in   one tick or one pose reload          kind, vel_x, vel_y, turn_rate, elapsed_us
// rsp_bus   out  pose after each request              pos_x_nm, pos_y_nm, heading_out
// csr_*     in   start pose register write            csr_index, csr_wdata
//
// a tick, accept to earliest next accept, runs one accept, two sine lookups,
// fourteen steps of the one shared 32x17 multiplier and accumulator, one handoff
// a reload is one accept and one handoff; every request gives exactly one response transaction
// reset is synchronous: pose and start registers take their reset values, no clearing pass
// the response sits in an output register, so the next request is taken while it waits;
// a finished pose waits in the handoff state only while an earlier response is not taken
module planar_odometry_integrator_top #(
   parameter int SINE_INDEX_BITS = poi_pkg::SINE_INDEX_BITS_DEF,
   parameter int TRIG_FRAC_BITS  = poi_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   poi_req_if.sink                           req_bus,
   poi_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_en,
   input  logic [poi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [poi_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import poi_pkg::*;

   // trig value, rotated velocity and its split for the dt product
   localparam int TW       = TRIG_FRAC_BITS + 2;
   localparam int RW       = TW + 17;
   localparam int LOW_W    = RW / 2;
   localparam int QTR      = 1 << (SINE_INDEX_BITS - 2);
   localparam int RND_HALF = 1 << (TRIG_FRAC_BITS - 1);
   localparam int PROD_W   = MUL_A_W + MUL_B_W;

   localparam logic signed [ACC_W-1:0] HEAD_RND = {{(ACC_W-HEAD_W){1'b0}}, 1'b1, {(HEAD_W-1){1'b0}}};

   // saturating pose update
   function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] p,
                                                       input logic signed [POS_W-1:0] d);
      logic signed [POS_W:0] s;
      s = (POS_W+1)'(p) + (POS_W+1)'(d);
      if (s[POS_W] != s[POS_W-1]) begin
         return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      return s[POS_W-1:0];
   endfunction

   poi_state_type                state_ff, state_in;
   poi_step_type                 step_ff, step_in;

   // configuration and pose
   logic signed [POS_W-1:0]      start_x_ff, start_x_in;
   logic signed [POS_W-1:0]      start_y_ff, start_y_in;
   logic [HEAD_W-1:0]            start_h_ff, start_h_in;
   logic signed [POS_W-1:0]      pose_x_ff, pose_x_in;
   logic signed [POS_W-1:0]      pose_y_ff, pose_y_in;
   logic [HEAD_W-1:0]            head_ff, head_in;

   // captured tick
   logic signed [VEL_W-1:0]      vx_ff, vx_in;
   logic signed [VEL_W-1:0]      vy_ff, vy_in;
   logic signed [VEL_W-1:0]      w_ff, w_in;
   logic [DT_W-1:0]              dt_ff, dt_in;
   logic [SINE_INDEX_BITS-1:0]   idx_ff, idx_in;

   // working registers
   logic signed [TW-1:0]         sin_ff, sin_in;
   logic signed [TW-1:0]         cos_ff, cos_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [RW-1:0]         rotx_ff, rotx_in;
   logic signed [RW-1:0]         roty_ff, roty_in;
   logic signed [POS_W-1:0]      delta_ff, delta_in;
   logic [HEAD_W-2:0]            mag_ff, mag_in;
   logic                         neg_ff, neg_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]      rsp_x_ff, rsp_x_in;
   logic signed [POS_W-1:0]      rsp_y_ff, rsp_y_in;
   logic [HEAD_W-1:0]            rsp_h_ff, rsp_h_in;

   logic [SINE_INDEX_BITS-1:0]   rom_idx;
   logic signed [TW-1:0]         rom_val;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic [SINE_INDEX_BITS+1:0]   idx_sum;
   logic signed [ACC_W-1:0]      rnd_sum;
   logic signed [ACC_W-1:0]      rnd_q;
   logic signed [PROD_W-1:0]     prod_abs;
   logic                         req_take;

   poi_sine_rom #(
      .SINE_INDEX_BITS (SINE_INDEX_BITS),
      .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
   ) u_sine_rom (
      .angle_idx (rom_idx),
      .sine_val  (rom_val)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign req_take            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pos_x_nm    = rsp_x_ff;
   assign rsp_bus.pos_y_nm    = rsp_y_ff;
   assign rsp_bus.heading_out = rsp_h_ff;

   // one table read a cycle: sine first, cosine a quarter turn on
   assign rom_idx = (state_ff == ST_COS) ? (idx_ff + SINE_INDEX_BITS'(QTR)) : idx_ff;

   // nearest table entry to the stored heading
   assign idx_sum = {1'b0, head_ff[HEAD_W-1:HEAD_W-1-SINE_INDEX_BITS]} + 1'b1;

   // round to nearest, ties away from zero
   assign rnd_sum  = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(RND_HALF - 1) : ACC_W'(RND_HALF));
   assign rnd_q    = rnd_sum >>> TRIG_FRAC_BITS;
   assign prod_abs = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         STEP_VX_COS: begin
            mul_a = MUL_A_W'(cos_ff);
            mul_b = MUL_B_W'(vx_ff);
         end
         STEP_VY_SIN: begin
            mul_a = MUL_A_W'(sin_ff);
            mul_b = MUL_B_W'(vy_ff);
         end
         STEP_VX_SIN: begin
            mul_a = MUL_A_W'(sin_ff);
            mul_b = MUL_B_W'(vx_ff);
         end
         STEP_VY_COS: begin
            mul_a = MUL_A_W'(cos_ff);
            mul_b = MUL_B_W'(vy_ff);
         end
         STEP_XLO_DT: begin
            mul_a = MUL_A_W'($signed({1'b0, rotx_ff[LOW_W-1:0]}));
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
         STEP_XHI_DT: begin
            mul_a = MUL_A_W'($signed(rotx_ff[RW-1:LOW_W]));
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
         STEP_YLO_DT: begin
            mul_a = MUL_A_W'($signed({1'b0, roty_ff[LOW_W-1:0]}));
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
         STEP_YHI_DT: begin
            mul_a = MUL_A_W'($signed(roty_ff[RW-1:LOW_W]));
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
         STEP_TURN_DT: begin
            mul_a = MUL_A_W'(w_ff);
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
         STEP_GAIN_LO: begin
            mul_a = MUL_A_W'($signed({1'b0, mag_ff}));
            mul_b = MUL_B_W'($signed({1'b0, HEAD_GAIN_Q32[GAIN_SPLIT-1:0]}));
         end
         STEP_GAIN_HI: begin
            mul_a = MUL_A_W'($signed({1'b0, mag_ff}));
            mul_b = MUL_B_W'($signed({1'b0, HEAD_GAIN_Q32[HEAD_W-1:GAIN_SPLIT]}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer, next state and datapath
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      start_h_in   = start_h_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      head_in      = head_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      w_in         = w_ff;
      dt_in        = dt_ff;
      idx_in       = idx_ff;
      sin_in       = sin_ff;
      cos_in       = cos_ff;
      prod_in      = mul_a * mul_b;
      acc_in       = acc_ff;
      rotx_in      = rotx_ff;
      roty_in      = roty_ff;
      delta_in     = delta_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_h_in     = rsp_h_ff;

      if (csr_write_en) begin
         unique case (poi_csr_type'(csr_index))
            CSR_START_X:       start_x_in = csr_wdata[POS_W-1:0];
            CSR_START_Y:       start_y_in = csr_wdata[POS_W-1:0];
            CSR_START_HEADING: start_h_in = csr_wdata[HEAD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (poi_kind_type'(req_bus.kind) == KIND_RELOAD) begin
                  pose_x_in = start_x_ff;
                  pose_y_in = start_y_ff;
                  head_in   = start_h_ff;
                  state_in  = ST_DONE;
               end else begin
                  vx_in    = req_bus.vel_x;
                  vy_in    = req_bus.vel_y;
                  w_in     = req_bus.turn_rate;
                  dt_in    = req_bus.elapsed_us;
                  idx_in   = idx_sum[SINE_INDEX_BITS:1];
                  state_in = ST_SIN;
               end
            end
         end
         ST_SIN: begin
            sin_in   = rom_val;
            state_in = ST_COS;
         end
         ST_COS: begin
            cos_in   = rom_val;
            step_in  = STEP_VX_COS;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            step_in = poi_step_type'(step_ff + 4'd1);
            case (step_ff)
               STEP_VY_SIN:  acc_in = ACC_W'(prod_ff);
               STEP_VX_SIN:  acc_in = acc_ff - ACC_W'(prod_ff);
               STEP_VY_COS: begin
                  acc_in  = ACC_W'(prod_ff);
                  rotx_in = acc_ff[RW-1:0];
               end
               STEP_XLO_DT:  acc_in = acc_ff + ACC_W'(prod_ff);
               STEP_XHI_DT: begin
                  acc_in  = ACC_W'(prod_ff);
                  roty_in = acc_ff[RW-1:0];
               end
               STEP_YLO_DT:  acc_in = acc_ff + (ACC_W'(prod_ff) <<< LOW_W);
               STEP_YHI_DT: begin
                  acc_in   = ACC_W'(prod_ff);
                  delta_in = rnd_q[POS_W-1:0];
               end
               STEP_TURN_DT: begin
                  acc_in    = acc_ff + (ACC_W'(prod_ff) <<< LOW_W);
                  pose_x_in = sat_add(pose_x_ff, delta_ff);
               end
               STEP_TURN_MAG: begin
                  delta_in = rnd_q[POS_W-1:0];
                  mag_in   = prod_abs[HEAD_W-2:0];
                  neg_in   = prod_ff[PROD_W-1];
               end
               STEP_GAIN_LO: pose_y_in = sat_add(pose_y_ff, delta_ff);
               STEP_GAIN_HI: acc_in = ACC_W'(prod_ff) + HEAD_RND;
               STEP_GAIN_SUM: acc_in = acc_ff + (ACC_W'(prod_ff) <<< GAIN_SPLIT);
               STEP_HEADING: begin
                  // binary angle wraps on its own
                  if (neg_ff) begin
                     head_in = head_ff - acc_ff[2*HEAD_W-1:HEAD_W];
                  end else begin
                     head_in = head_ff + acc_ff[2*HEAD_W-1:HEAD_W];
                  end
                  step_in  = STEP_VX_COS;
                  state_in = ST_DONE;
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pose_x_ff;
               rsp_y_in     = pose_y_ff;
               rsp_h_in     = head_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_VX_COS;
         rsp_valid_ff <= 1'b0;
         start_x_ff   <= START_X_RESET;
         start_y_ff   <= START_Y_RESET;
         start_h_ff   <= START_H_RESET;
         pose_x_ff    <= START_X_RESET;
         pose_y_ff    <= START_Y_RESET;
         head_ff      <= START_H_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         start_h_ff   <= start_h_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         head_ff      <= head_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      w_ff     <= w_in;
      dt_ff    <= dt_in;
      idx_ff   <= idx_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rotx_ff  <= rotx_in;
      roty_ff  <= roty_in;
      delta_ff <= delta_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_h_ff <= rsp_h_in;
   end

endmodule

### rtl/core/poi_sine_rom.sv
module poi_sine_rom #(
   parameter int SINE_INDEX_BITS = poi_pkg::SINE_INDEX_BITS_DEF,
   parameter int TRIG_FRAC_BITS  = poi_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic [SINE_INDEX_BITS-1:0]  angle_idx,
   output logic signed [TRIG_FRAC_BITS+1:0] sine_val
);
   import poi_pkg::*;

   localparam int QTR    = 1 << (SINE_INDEX_BITS - 2);
   localparam int ADDR_W = SINE_INDEX_BITS - 1;

   logic [TRIG_FRAC_BITS:0]    qtab [0:QTR];
   logic [1:0]                 quad;
   logic [ADDR_W-1:0]          r_ext;
   logic [ADDR_W-1:0]          addr;
   logic [TRIG_FRAC_BITS:0]    mag;

   // quarter wave built at elaboration, other quadrants mirror it
   for (genvar g = 0; g <= QTR; g++) begin : g_qtab
      localparam logic [QSINE_W-1:0] QV = quarter_sine(g, SINE_INDEX_BITS, TRIG_FRAC_BITS);
      assign qtab[g] = QV[TRIG_FRAC_BITS:0];
   end

   always_comb begin
      quad  = angle_idx[SINE_INDEX_BITS-1:SINE_INDEX_BITS-2];
      r_ext = {1'b0, angle_idx[SINE_INDEX_BITS-3:0]};
      addr  = quad[0] ? (ADDR_W'(QTR) - r_ext) : r_ext;
      mag   = qtab[addr];
      if (quad[1]) begin
         sine_val = -$signed({1'b0, mag});
      end else begin
         sine_val = $signed({1'b0, mag});
      end
   end

endmodule

### rtl/core/poi_checker.sv
module poi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] rsp_pos_x,
   input logic [47:0] rsp_pos_y,
   input logic [31:0] rsp_heading
);

   // a response transaction is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pos_x) && $stable(rsp_pos_y)
                                  && $stable(rsp_heading))
      else $error("stalled response payload changed");

   // a tick keeps the block busy
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind |=> !req_ready)
      else $error("ready while a tick is in progress");

   // a reload with a free output goes through the handoff state into the response register without a wait
   a_reload_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind && !rsp_valid |-> ##2 rsp_valid)
      else $error("reload response late");

endmodule

bind planar_odometry_integrator_top poi_checker u_poi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_kind    (req_bus.kind),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_pos_x   (rsp_bus.pos_x_nm),
   .rsp_pos_y   (rsp_bus.pos_y_nm),
   .rsp_heading (rsp_bus.heading_out)
);
